/* hdl/dsf_pkg.sv */
// Shared types and constants for the damped spring force block.
// Used by the datapath, controller, top level, checker and testbench; depends on nothing.
`default_nettype none
package dsf_pkg;

	// Stream widths: twelve 32-bit input fields, three 32-bit forces, three flags.
	localparam int IN_W      = 384;
	localparam int OUT_W     = 96;
	localparam int USER_W    = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;

	// Fraction bits of the unit direction vector.
	localparam int DIR_BITS = 30;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SPRING_K  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REST_LEN  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_3D   = 8'd3;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MWAIT,
		ST_RINIT,
		ST_ROOT,
		ST_DINIT,
		ST_DIV,
		ST_FIN
	} state_t;

	// Multiply operations, in the order the controller issues them.
	typedef enum logic [3:0] {
		MO_SQ_X,
		MO_SQ_Y,
		MO_SQ_Z,
		MO_SPRING,
		MO_DOT_X,
		MO_DOT_Y,
		MO_DOT_Z,
		MO_DAMP,
		MO_F_X,
		MO_F_Y,
		MO_F_Z,
		MO_VS_X,
		MO_VS_Y,
		MO_FS_X,
		MO_FS_Y
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      mul_start;
		logic      mul_wb;
		mul_op_t   op;
		logic      root_init;
		logic      root_step;
		logic      div_init;
		logic      div_step;
		logic      div_last;
		logic [1:0] axis;
		logic      out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mul_done;
		logic dist_zero;
		logic mode_3d;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hdl/dsf_mul.sv */
// Shared multiplier: 64-bit by 33-bit unsigned magnitudes, built from two
// 32 by 33 partial products. Depends on nothing.
`default_nettype none
module dsf_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a_mag,
	input  logic [32:0] b_mag,
	output logic        done,
	output logic [96:0] prod
);

	logic [63:0] a_q;
	logic [32:0] b_q;
	logic [64:0] pl_q;
	logic [64:0] ph_q;
	logic [96:0] prod_q;
	logic [3:0]  step_q;

	// One-hot step marker: operands, low product, high product, sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= {step_q[2:0], start};
		end
	end

	// Operand capture and partial products.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_mag;
			b_q <= b_mag;
		end
		if (step_q[0]) begin
			pl_q <= a_q[31:0] * b_q;
		end
		if (step_q[1]) begin
			ph_q <= a_q[63:32] * b_q;
		end
		if (step_q[2]) begin
			prod_q <= {32'b0, pl_q} + {ph_q, 32'b0};
		end
	end

	assign done = step_q[3];
	assign prod = prod_q;

endmodule
`default_nettype wire

/* hdl/dsf_dp.sv */
// Datapath: operand registers, square root and division iterations, multiply
// writeback with saturation, snap check and the output register. Uses dsf_pkg, dsf_mul.
`default_nettype none
module dsf_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dsf_pkg::dp_cmd_t             cmd,
	output dsf_pkg::dp_stat_t            stat,
	input  logic [dsf_pkg::IN_W-1:0]     in_data,
	input  logic signed [31:0]           spring_k,
	input  logic signed [31:0]           damping_coeff,
	input  logic [30:0]                  rest_length,
	input  logic                         mode_3d,
	output logic [dsf_pkg::OUT_W-1:0]    out_data,
	output logic [dsf_pkg::USER_W-1:0]   out_flags,
	output logic                         out_valid,
	input  logic                         out_ready
);
	import dsf_pkg::*;

	localparam logic [65:0] ONE_SQ = 66'd1 << (2 * FRAC_BITS);

	// Item registers.
	logic signed [32:0] d_q [3];
	logic signed [32:0] rv_q [3];
	logic signed [31:0] va_q [2];
	logic signed [31:0] u_q [3];
	logic signed [31:0] f_q [3];
	logic [65:0]        sq_q;
	logic signed [63:0] spring_q;
	logic signed [35:0] dot_q;
	logic signed [63:0] mag_q;
	logic [63:0]        vs_q;
	logic [63:0]        fs_q;
	logic               snap_q;
	logic               fin_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;
	logic [USER_W-1:0]  out_flags_q;

	// Square root and division state.
	logic [32:0] root_q;
	logic [35:0] rrem_q;
	logic [65:0] rsh_q;
	logic [32:0] drem_q;
	logic [30:0] dnb_q;
	logic [30:0] quo_q;

	// Input unpacking, with the z parts zeroed in planar mode.
	logic signed [32:0] d_in [3];
	logic signed [32:0] rv_in [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (mode_3d || (i != 2)) begin
				d_in[i] = $signed({in_data[32*i+31], in_data[32*i +: 32]})
					- $signed({in_data[32*(3+i)+31], in_data[32*(3+i) +: 32]});
				rv_in[i] = $signed({in_data[192+32*i+31], in_data[192+32*i +: 32]})
					- $signed({in_data[288+32*i+31], in_data[288+32*i +: 32]});
			end else begin
				d_in[i]  = '0;
				rv_in[i] = '0;
			end
		end
	end

	// Magnitudes of the stored operands.
	logic [32:0] d_mag [3];
	logic [32:0] rv_mag [3];
	logic [30:0] u_mag [3];
	logic [31:0] va_mag [2];
	logic [31:0] f_mag [2];
	logic signed [33:0] sx;
	logic [33:0] sx_mag;
	logic [31:0] k_mag;
	logic [31:0] c_mag;
	logic [35:0] dot_mag;
	logic [63:0] mag_mag;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_mag[i]  = d_q[i][32] ? -d_q[i] : d_q[i];
			rv_mag[i] = rv_q[i][32] ? -rv_q[i] : rv_q[i];
			u_mag[i]  = u_q[i][31] ? 31'(-u_q[i]) : 31'(u_q[i]);
		end
		for (int i = 0; i < 2; i++) begin
			va_mag[i] = va_q[i][31] ? -va_q[i] : va_q[i];
			f_mag[i]  = f_q[i][31] ? -f_q[i] : f_q[i];
		end
		sx      = $signed({1'b0, root_q}) - $signed({3'b0, rest_length});
		sx_mag  = sx[33] ? -sx : sx;
		k_mag   = spring_k[31] ? -spring_k : spring_k;
		c_mag   = damping_coeff[31] ? -damping_coeff : damping_coeff;
		dot_mag = dot_q[35] ? -dot_q : dot_q;
		mag_mag = mag_q[63] ? -mag_q : mag_q;
	end

	// Multiplier operand selection and result sign.
	logic [63:0] mul_a;
	logic [32:0] mul_b;
	logic        mul_neg;
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (cmd.op)
			MO_SQ_X: begin
				mul_a = {31'b0, d_mag[0]};
				mul_b = d_mag[0];
			end
			MO_SQ_Y: begin
				mul_a = {31'b0, d_mag[1]};
				mul_b = d_mag[1];
			end
			MO_SQ_Z: begin
				mul_a = {31'b0, d_mag[2]};
				mul_b = d_mag[2];
			end
			MO_SPRING: begin
				mul_a   = {30'b0, sx_mag};
				mul_b   = {1'b0, k_mag};
				mul_neg = sx[33] ^ spring_k[31];
			end
			MO_DOT_X: begin
				mul_a   = {31'b0, rv_mag[0]};
				mul_b   = {2'b0, u_mag[0]};
				mul_neg = rv_q[0][32] ^ u_q[0][31];
			end
			MO_DOT_Y: begin
				mul_a   = {31'b0, rv_mag[1]};
				mul_b   = {2'b0, u_mag[1]};
				mul_neg = rv_q[1][32] ^ u_q[1][31];
			end
			MO_DOT_Z: begin
				mul_a   = {31'b0, rv_mag[2]};
				mul_b   = {2'b0, u_mag[2]};
				mul_neg = rv_q[2][32] ^ u_q[2][31];
			end
			MO_DAMP: begin
				mul_a   = {28'b0, dot_mag};
				mul_b   = {1'b0, c_mag};
				mul_neg = damping_coeff[31] ^ dot_q[35];
			end
			MO_F_X: begin
				mul_a   = mag_mag;
				mul_b   = {2'b0, u_mag[0]};
				mul_neg = u_q[0][31] ^ mag_q[63];
			end
			MO_F_Y: begin
				mul_a   = mag_mag;
				mul_b   = {2'b0, u_mag[1]};
				mul_neg = u_q[1][31] ^ mag_q[63];
			end
			MO_F_Z: begin
				mul_a   = mag_mag;
				mul_b   = {2'b0, u_mag[2]};
				mul_neg = u_q[2][31] ^ mag_q[63];
			end
			MO_VS_X: begin
				mul_a = {32'b0, va_mag[0]};
				mul_b = {1'b0, va_mag[0]};
			end
			MO_VS_Y: begin
				mul_a = {32'b0, va_mag[1]};
				mul_b = {1'b0, va_mag[1]};
			end
			MO_FS_X: begin
				mul_a = {32'b0, f_mag[0]};
				mul_b = {1'b0, f_mag[0]};
			end
			MO_FS_Y: begin
				mul_a = {32'b0, f_mag[1]};
				mul_b = {1'b0, f_mag[1]};
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_neg = 1'b0;
			end
		endcase
	end

	logic        mul_done;
	logic [96:0] prod;

	dsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a_mag  (mul_a),
		.b_mag  (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// Product scaling, wide saturation, sign and 32-bit saturation.
	logic [96:0]        sh;
	logic [61:0]        sat62;
	logic signed [63:0] res;
	logic signed [31:0] res32;
	logic [63:0]        fs_next;
	logic               snap_cond;
	always_comb begin
		if (cmd.op == MO_SPRING || cmd.op == MO_DAMP) begin
			sh = prod >> FRAC_BITS;
		end else begin
			sh = prod >> DIR_BITS;
		end
		sat62 = (|sh[96:62]) ? {62{1'b1}} : sh[61:0];
		res   = mul_neg ? -$signed({2'b0, sat62}) : $signed({2'b0, sat62});
		if (res > 64'sd2147483647) begin
			res32 = 32'sh7FFFFFFF;
		end else if (res < -64'sd2147483648) begin
			res32 = 32'sh80000000;
		end else begin
			res32 = res[31:0];
		end
		fs_next   = fs_q + prod[63:0];
		snap_cond = (sq_q < ONE_SQ) && ({2'b0, vs_q} < ONE_SQ)
			&& ({2'b0, fs_next} < ONE_SQ);
	end

	// Square root step: one result bit per cycle.
	logic [35:0] rr;
	logic [35:0] rtrial;
	logic        rge;
	always_comb begin
		rr     = {rrem_q[33:0], rsh_q[65:64]};
		rtrial = {1'b0, root_q, 2'b01};
		rge    = rr >= rtrial;
	end

	// Restoring division step: one quotient bit per cycle.
	logic [33:0] dt;
	logic        dge;
	logic [32:0] drem_next;
	logic [30:0] quo_next;
	always_comb begin
		dt        = {drem_q, dnb_q[30]};
		dge       = dt >= {1'b0, root_q};
		drem_next = dge ? 33'(dt - {1'b0, root_q}) : dt[32:0];
		quo_next  = {quo_q[29:0], dge};
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i]  <= d_in[i];
				rv_q[i] <= rv_in[i];
				f_q[i]  <= '0;
			end
			va_q[0] <= in_data[192 +: 32];
			va_q[1] <= in_data[224 +: 32];
			sq_q    <= '0;
			dot_q   <= '0;
			vs_q    <= '0;
			fs_q    <= '0;
			snap_q  <= 1'b0;
		end
		if (cmd.mul_wb) begin
			case (cmd.op)
				MO_SQ_X, MO_SQ_Y, MO_SQ_Z: sq_q <= sq_q + prod[65:0];
				MO_SPRING: spring_q <= res;
				MO_DOT_X, MO_DOT_Y, MO_DOT_Z: dot_q <= dot_q + $signed(res[35:0]);
				MO_DAMP: mag_q <= spring_q - res;
				MO_F_X: f_q[0] <= res32;
				MO_F_Y: f_q[1] <= res32;
				MO_F_Z: f_q[2] <= res32;
				MO_VS_X, MO_VS_Y: vs_q <= vs_q + prod[63:0];
				MO_FS_X: fs_q <= fs_next;
				MO_FS_Y: begin
					fs_q   <= fs_next;
					snap_q <= snap_cond;
				end
				default: spring_q <= spring_q;
			endcase
		end
		if (cmd.root_init) begin
			root_q <= '0;
			rrem_q <= '0;
			rsh_q  <= sq_q;
		end
		if (cmd.root_step) begin
			rrem_q <= rge ? rr - rtrial : rr;
			root_q <= {root_q[31:0], rge};
			rsh_q  <= {rsh_q[63:0], 2'b00};
		end
		if (cmd.div_init) begin
			drem_q <= {1'b0, d_mag[cmd.axis][32:1]};
			dnb_q  <= {d_mag[cmd.axis][0], 30'b0};
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			drem_q <= drem_next;
			dnb_q  <= {dnb_q[29:0], 1'b0};
			quo_q  <= quo_next;
		end
		if (cmd.div_last) begin
			u_q[cmd.axis] <= d_q[cmd.axis][32] ? -$signed({1'b0, quo_next})
				: $signed({1'b0, quo_next});
		end
		if (cmd.out_load) begin
			out_data_q  <= {f_q[2], f_q[1], f_q[0]};
			out_flags_q <= {fin_q, snap_q, (sq_q == '0)};
		end
	end

	// Sticky finished flag and output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul_wb && cmd.op == MO_FS_Y && snap_cond) begin
				fin_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.mul_done  = mul_done;
	assign stat.dist_zero = (sq_q == '0);
	assign stat.mode_3d   = mode_3d;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_data  = out_data_q;
	assign out_flags = out_flags_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* hdl/dsf_ctrl.sv */
// Controller: sequences loading, squares, square root, three divisions and the
// multiply chain, then hands the result to the output register. Uses dsf_pkg.
`default_nettype none
module dsf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output dsf_pkg::dp_cmd_t  cmd,
	input  dsf_pkg::dp_stat_t stat
);
	import dsf_pkg::*;

	localparam logic [5:0] ROOT_LAST = 6'd32;
	localparam logic [5:0] DIV_LAST  = 6'd30;
	localparam logic [1:0] AXIS_Z    = 2'd2;

	state_t     state_q, state_d;
	mul_op_t    op_q;
	logic [5:0] cnt_q;
	logic [1:0] axis_q;

	function automatic mul_op_t op_succ(input mul_op_t op);
		mul_op_t nxt;
		case (op)
			MO_SQ_X:   nxt = MO_SQ_Y;
			MO_SQ_Y:   nxt = MO_SQ_Z;
			MO_SQ_Z:   nxt = MO_SPRING;
			MO_SPRING: nxt = MO_DOT_X;
			MO_DOT_X:  nxt = MO_DOT_Y;
			MO_DOT_Y:  nxt = MO_DOT_Z;
			MO_DOT_Z:  nxt = MO_DAMP;
			MO_DAMP:   nxt = MO_F_X;
			MO_F_X:    nxt = MO_F_Y;
			MO_F_Y:    nxt = MO_F_Z;
			MO_F_Z:    nxt = MO_VS_X;
			MO_VS_X:   nxt = MO_VS_Y;
			MO_VS_Y:   nxt = MO_FS_X;
			MO_FS_X:   nxt = MO_FS_Y;
			default:   nxt = MO_SQ_X;
		endcase
		return nxt;
	endfunction

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_MWAIT;
			ST_MWAIT: begin
				if (stat.mul_done) begin
					case (op_q)
						MO_SQ_Z: state_d = ST_RINIT;
						MO_F_Z:  state_d = stat.mode_3d ? ST_FIN : ST_MUL;
						MO_FS_Y: state_d = ST_FIN;
						default: state_d = ST_MUL;
					endcase
				end
			end
			ST_RINIT: state_d = stat.dist_zero ? ST_FIN : ST_ROOT;
			ST_ROOT: begin
				if (cnt_q == '0) state_d = ST_DINIT;
			end
			ST_DINIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) state_d = (axis_q == AXIS_Z) ? ST_MUL : ST_DINIT;
			end
			ST_FIN: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.op        = op_q;
		cmd.axis      = axis_q;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.mul_start = (state_q == ST_MUL);
		cmd.mul_wb    = (state_q == ST_MWAIT) && stat.mul_done;
		cmd.root_init = (state_q == ST_RINIT) && !stat.dist_zero;
		cmd.root_step = (state_q == ST_ROOT);
		cmd.div_init  = (state_q == ST_DINIT);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_last  = (state_q == ST_DIV) && (cnt_q == '0);
		cmd.out_load  = (state_q == ST_FIN) && stat.out_free;
	end

	// State, operation, iteration count and axis registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= MO_SQ_X;
			cnt_q   <= '0;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					op_q   <= MO_SQ_X;
					axis_q <= '0;
				end
				ST_MWAIT: begin
					if (stat.mul_done) op_q <= op_succ(op_q);
				end
				ST_RINIT: cnt_q <= ROOT_LAST;
				ST_ROOT:  cnt_q <= cnt_q - 6'd1;
				ST_DINIT: cnt_q <= DIV_LAST;
				ST_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) axis_q <= axis_q + 2'd1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/damped_spring_force.sv */
// Top level of the damped spring force block: configuration registers and the
// controller and datapath instances. Uses dsf_pkg, dsf_ctrl, dsf_dp.
//
//   channel   direction  beat contents
//   s_axis    in         tdata: pos_a xyz, pos_b xyz, vel_a xyz, vel_b xyz
//   m_axis    out        tdata: force xyz; tuser: too_close, snapped, finished
//   cfg       in         cfg_index selects register, cfg_data holds its value
//
// One item at a time. The work on a beat is set by the 33-step square root, three
// 31-step divisions and the shared multiplier; planar mode adds the four products
// of the snap check, and a zero distance skips straight to the output register.
// The output register lets the next item be taken while a result waits.
// Reset clears the controller, the finished flag and the config; k resets to 1.0.
`default_nettype none
module damped_spring_force #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
	// vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z (32 bits each)
	input  logic [dsf_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// force_x, force_y, force_z (32 bits each)
	output logic [dsf_pkg::OUT_W-1:0]       m_axis_tdata,
	// too_close, snapped, finished
	output logic [dsf_pkg::USER_W-1:0]      m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dsf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dsf_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import dsf_pkg::*;

	localparam logic [31:0] K_RESET = 32'd1 << FRAC_BITS;

	logic signed [31:0] spring_k_q;
	logic signed [31:0] damping_q;
	logic [30:0]        rest_q;
	logic               mode_3d_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_k_q <= K_RESET;
			damping_q  <= '0;
			rest_q     <= '0;
			mode_3d_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPRING_K: spring_k_q <= cfg_data;
				REG_DAMPING:  damping_q  <= cfg_data;
				REG_REST_LEN: rest_q     <= cfg_data[30:0];
				REG_MODE_3D:  mode_3d_q  <= cfg_data[0];
				default:      mode_3d_q  <= mode_3d_q;
			endcase
		end
	end

	dsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	dsf_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_data       (s_axis_tdata),
		.spring_k      (spring_k_q),
		.damping_coeff (damping_q),
		.rest_length   (rest_q),
		.mode_3d       (mode_3d_q),
		.out_data      (m_axis_tdata),
		.out_flags     (m_axis_tuser),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready)
	);

endmodule
`default_nettype wire

/* hdl/dsf_checker.sv */
// Port-level checks for the damped spring force block, bound to the top level.
// Uses dsf_pkg for widths only.
`default_nettype none
module dsf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dsf_pkg::OUT_W-1:0]       m_axis_tdata,
	input logic [dsf_pkg::USER_W-1:0]      m_axis_tuser
);

	// A result beat stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped before it was taken");

	// Zero distance gives zero force and no snap.
	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
		else $error("too_close beat carries force or snap");

	// A snap always shows the finished flag.
	a_snap_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[2])
		else $error("snap without finished flag");

	// Snaps happen only in planar mode, where the z force is zero.
	a_snap_planar: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[95:64] == '0))
		else $error("snap with nonzero z force");

endmodule

bind damped_spring_force dsf_checker u_dsf_checker (.*);
`default_nettype wire

/* tb/damped_spring_force_test.sv */
// Self-checking testbench for damped_spring_force: random and directed body pairs
// are streamed in, every force beat is checked against a local fixed-point predictor.
// Depends on dsf_pkg and the damped_spring_force RTL only.
`default_nettype none
module damped_spring_force_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dsf_pkg::*;

	localparam int FRAC = 16;
	localparam longint WIDE_LIM = 64'sh3FFFFFFFFFFFFFFF;
	localparam int STALL_LIMIT = 20000;
	localparam logic [31:0] S_MAX = 32'h7FFFFFFF;
	localparam logic [31:0] S_MIN = 32'h80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [USER_W-1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	damped_spring_force #(.FRAC_BITS(FRAC)) uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the configuration and the sticky flag.
	longint model_k;
	longint model_damp;
	longint model_rest;
	logic model_3d;
	logic model_finished;

	logic [IN_W-1:0] pending_items[$];
	logic [CFG_IDX_W+CFG_DAT_W-1:0] pending_regs[$];
	logic [98:0] expected_forces[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left;
	int errors = 0;
	int quiet_cycles;

	// trunc(a*b / 2^sh) with saturation to the wide product limit.
	function automatic longint scaled_product(input longint a, input longint b, input int sh);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [127:0] p;
		longint r;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = ({64'b0, ma} * {64'b0, mb}) >> sh;
		r = (p > 128'(WIDE_LIM)) ? WIDE_LIM : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Force on the second body plus flags, packed {finished, snapped, too_close, fz, fy, fx}.
	function automatic logic [98:0] spring_force(input logic [IN_W-1:0] it);
		longint d[3];
		longint rv[3];
		longint va[3];
		longint dir[3];
		longint f[3];
		logic [63:0] t;
		logic [127:0] sq_dist;
		logic [127:0] vs;
		logic [127:0] fs;
		logic [127:0] rem;
		logic [127:0] root;
		logic [127:0] trial;
		longint span_len;
		longint spring;
		longint dot;
		longint damp;
		longint mag;
		logic close_flag;
		logic snap_flag;
		int n;
		n = model_3d ? 3 : 2;
		sq_dist = '0;
		close_flag = 1'b0;
		snap_flag = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d[i] = 0; rv[i] = 0; va[i] = 0; f[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			d[i] = longint'($signed(it[32*i +: 32])) - longint'($signed(it[32*(3+i) +: 32]));
			va[i] = longint'($signed(it[32*(6+i) +: 32]));
			rv[i] = va[i] - longint'($signed(it[32*(9+i) +: 32]));
			t = (d[i] < 0) ? -d[i] : d[i];
			sq_dist += {64'b0, t} * {64'b0, t};
		end
		if (sq_dist == 0) begin
			close_flag = 1'b1;
		end else begin
			// Bitwise integer square root, two bits per step.
			rem = '0;
			root = '0;
			for (int i = 33; i >= 0; i--) begin
				rem = (rem << 2) | sq_dist[2*i +: 2];
				trial = (root << 2) | 1;
				if (rem >= trial) begin
					rem -= trial;
					root = (root << 1) | 1;
				end else begin
					root = root << 1;
				end
			end
			span_len = longint'(root[63:0]);
			for (int i = 0; i < 3; i++) begin
				t = (d[i] < 0) ? -d[i] : d[i];
				root = ({64'b0, t} << DIR_BITS) / span_len;
				dir[i] = (d[i] < 0) ? -longint'(root[63:0]) : longint'(root[63:0]);
			end
			spring = scaled_product(span_len - model_rest, model_k, FRAC);
			dot = 0;
			for (int i = 0; i < 3; i++)
				dot += scaled_product(rv[i], dir[i], DIR_BITS);
			damp = scaled_product(model_damp, dot, FRAC);
			mag = spring - damp;
			for (int i = 0; i < 3; i++)
				f[i] = sat32(scaled_product(dir[i], mag, DIR_BITS));
			// Planar stop check, everything compared as squares against one.
			if (!model_3d) begin
				vs = '0;
				fs = '0;
				for (int i = 0; i < 3; i++) begin
					t = (va[i] < 0) ? -va[i] : va[i];
					vs += {64'b0, t} * {64'b0, t};
					t = (f[i] < 0) ? -f[i] : f[i];
					fs += {64'b0, t} * {64'b0, t};
				end
				if (sq_dist < (128'd1 << (2*FRAC)) && vs < (128'd1 << (2*FRAC))
						&& fs < (128'd1 << (2*FRAC))) begin
					snap_flag = 1'b1;
					model_finished = 1'b1;
				end
			end
		end
		return {model_finished, snap_flag, close_flag, f[2][31:0], f[1][31:0], f[0][31:0]};
	endfunction

	// Input driver: one beat per handshake, gaps drawn from send_idle_pct.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_forces.push_back(spring_force(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tdata <= pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Register write channel; the predictor copy follows each accepted write.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SPRING_K: model_k = longint'($signed(cfg_data));
					REG_DAMPING: model_damp = longint'($signed(cfg_data));
					REG_REST_LEN: model_rest = longint'({1'b0, cfg_data[30:0]});
					REG_MODE_3D: model_3d = cfg_data[0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_regs.size() > 0) begin
					{cfg_index, cfg_data} <= pending_regs.pop_front();
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: random stalls, one long hold-off on request, field checks.
	always @(posedge clk or negedge arst_n) begin
		logic [98:0] want;
		logic [98:0] got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata};
				if (expected_forces.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected result beat %h", got);
				end else begin
					want = expected_forces.pop_front();
					for (int i = 0; i < 6; i++) begin
						if (i < 3 && got[32*i +: 32] !== want[32*i +: 32]) begin
							errors++;
							if (errors <= 10)
								$display("ERROR: force[%0d] expected %h got %h",
									i, want[32*i +: 32], got[32*i +: 32]);
						end else if (i >= 3 && got[93+i] !== want[93+i]) begin
							errors++;
							if (errors <= 10)
								$display("ERROR: flag %0d expected %b got %b",
									i - 3, want[93+i], got[93+i]);
						end
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 3000;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_field(input int style);
		case (style)
			0: return $urandom;
			1: return $urandom_range(32'h40000) - 32'h20000;
			default: begin
				case ($urandom_range(4))
					0: return S_MAX;
					1: return S_MIN;
					2: return 32'h0;
					3: return 32'hFFFFFFFF;
					default: return 32'h1;
				endcase
			end
		endcase
	endfunction

	// Random pair of bodies: wide, nearby (snap territory), coincident or mixed.
	function automatic logic [IN_W-1:0] random_pair();
		logic [IN_W-1:0] it;
		int style;
		style = $urandom_range(99);
		for (int i = 0; i < 12; i++)
			it[32*i +: 32] = pick_field(style < 30 ? 0 : (style < 80 ? 1 : $urandom_range(2)));
		if (style >= 30 && style < 60) begin
			// Second body within about one unit of the first, slow first body.
			for (int i = 0; i < 3; i++) begin
				it[32*(3+i) +: 32] = it[32*i +: 32] + $urandom_range(32'h18000) - 32'hC000;
				it[32*(6+i) +: 32] = $urandom_range(32'h18000) - 32'hC000;
			end
		end else if (style >= 60 && style < 70) begin
			for (int i = 0; i < 2 + $urandom_range(1); i++)
				it[32*(3+i) +: 32] = it[32*i +: 32];
		end
		return it;
	endfunction

	function automatic logic [IN_W-1:0] make_pair(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] az, input logic [31:0] va, input logic [31:0] vb);
		return {vb, vb, vb, va, va, va, 32'h0, b, b, az, a, a};
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || expected_forces.size() != 0
			|| pending_regs.size() != 0 || cfg_valid);
	endtask

	task automatic set_regs(input logic [31:0] k, input logic [31:0] dmp,
			input logic [31:0] rest, input logic mode);
		wait_idle();
		pending_regs.push_back({REG_SPRING_K, k});
		pending_regs.push_back({REG_DAMPING, dmp});
		pending_regs.push_back({REG_REST_LEN, rest});
		pending_regs.push_back({REG_MODE_3D, 31'b0, mode});
		wait_idle();
	endtask

	task automatic run_random(input int count, input int sidle, input int rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		for (int i = 0; i < count; i++)
			pending_items.push_back(random_pair());
		wait_idle();
	endtask

	initial begin
		model_k = 64'sd65536;
		model_damp = 0;
		model_rest = 0;
		model_3d = 1'b0;
		model_finished = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed items under reset configuration (planar, k = 1.0).
		pending_items.push_back(make_pair(0, 0, 0, 0, 0));
		pending_items.push_back(make_pair(0, 0, S_MAX, 0, 0));
		pending_items.push_back(make_pair(32'h8000, 0, 0, 32'h100, 0));
		pending_items.push_back(make_pair(32'h10000, 0, 0, 0, 0));
		pending_items.push_back(make_pair(S_MAX, S_MIN, S_MIN, S_MAX, S_MIN));
		pending_items.push_back(make_pair(S_MIN, S_MAX, S_MAX, S_MIN, S_MAX));
		pending_items.push_back(make_pair(1, 0, 0, 32'hFFFFFFFF, 1));
		pending_items.push_back(make_pair(32'hFFFFFFFF, 0, 0, 0, 0));
		pending_items.push_back(make_pair(32'h4000, 32'h4000, 0, 0, 0));
		wait_idle();
		set_regs(32'h10000, 32'h10000, 32'h0, 1'b1);
		pending_items.push_back(make_pair(0, 0, 0, 0, 0));
		pending_items.push_back(make_pair(0, 0, 32'h1, 0, 0));
		pending_items.push_back(make_pair(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX));
		pending_items.push_back(make_pair(1, 0, 0, S_MAX, S_MIN));
		pending_items.push_back(make_pair(32'h8000, 0, 32'h8000, 32'h100, 0));
		wait_idle();

		// Random phases across register extremes and idling patterns.
		set_regs(S_MIN, S_MAX, S_MAX, 1'b1);
		run_random(180, 61, 0);
		set_regs(S_MAX, S_MIN, 32'h0, 1'b0);
		run_random(180, 0, 61);
		set_regs(32'h10000, 32'h0, 32'h0, 1'b0);
		run_random(180, 0, 0);
		set_regs(32'h8000, $urandom_range(32'h20000), 32'h8000, 1'b0);
		hold_req = 1'b1;
		run_random(180, 12, 12);
		set_regs($urandom, $urandom, $urandom, 1'b1);
		run_random(180, 61, 61);
		set_regs(32'h0, 32'h0, 32'h7FFFFFFF, 1'b0);
		run_random(180, 0, 0);
		set_regs($urandom_range(32'h30000), $urandom, $urandom_range(32'h20000), 1'b0);
		run_random(180, 61, 0);
		set_regs($urandom, $urandom_range(32'h10000), $urandom, 1'b1);
		run_random(180, 0, 61);

		repeat (300) @(negedge clk);
		if (expected_forces.size() != 0)
			errors++;
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
